>>> hdl/fpsa_pkg.sv
`default_nettype none
package fpsa_pkg;

  localparam int PAGE_SHIFT  = 12;
  localparam int FRAME_COUNT = 65536;
  localparam int FW          = $clog2(FRAME_COUNT);   // frame index bits
  localparam int LINK_W      = FW + 1;                // frame index plus null flag

  localparam int QUEUE_DEPTH = 2;
  localparam int QPW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_UNALIGNED = 3'd2;
  localparam logic [2:0] ST_KERNEL    = 3'd3;
  localparam logic [2:0] ST_BEYOND    = 3'd4;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_PUSH   = 2'd1;
  localparam logic [1:0] OP_REJECT = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;

  localparam logic [1:0] CFG_KERNEL_BASE = 2'd0;
  localparam logic [1:0] CFG_KERNEL_END  = 2'd1;
  localparam logic [1:0] CFG_PHYS_TOP    = 2'd2;

  typedef struct packed {
    logic [31:0] kernel_base;
    logic [31:0] kernel_end;
    logic [28:0] phys_top;
  } cfg_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [FW-1:0] frame;
    logic [2:0]    status;
  } entry_t;

endpackage
`default_nettype wire

>>> hdl/fpsa_ram.sv
`default_nettype none
module fpsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/fpsa_front.sv
`default_nettype none
module fpsa_front import fpsa_pkg::*; (
  input  wire logic        command,
  input  wire logic [31:0] page_addr,
  input  wire cfg_t        cfg,
  output entry_t           entry
);

  logic [31:0] phys;
  logic [31:0] frame_full;

  // Classify: checks in order alignment, kernel end, physical top.
  always_comb begin
    phys        = page_addr - cfg.kernel_base;
    frame_full  = phys >> PAGE_SHIFT;
    entry.frame = frame_full[FW-1:0];
    entry.op    = OP_REJECT;
    entry.status = ST_OK;
    if (command == CMD_ALLOC) begin
      entry.op = OP_ALLOC;
    end else if (page_addr[PAGE_SHIFT-1:0] != '0) begin
      entry.status = ST_UNALIGNED;
    end else if (page_addr < cfg.kernel_end) begin
      entry.status = ST_KERNEL;
    end else if ((phys >= {3'b000, cfg.phys_top}) || (frame_full >= 32'(FRAME_COUNT))) begin
      entry.status = ST_BEYOND;
    end else begin
      entry.op = OP_PUSH;
    end
  end

endmodule
`default_nettype wire

>>> hdl/fpsa_queue.sv
`default_nettype none
module fpsa_queue import fpsa_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        empty,
  output entry_t      head
);

  entry_t           slots [QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;

  assign full  = (count == QCW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> $stable(count))
    else $error("queue written while full");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    empty |=> !(count > $past(count) + 1'b1))
    else $error("queue count jumped");

endmodule
`default_nettype wire

>>> hdl/fpsa_back.sv
`default_nettype none
module fpsa_back import fpsa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        empty,
  input  wire entry_t      head,
  output logic             pop,
  input  wire logic [31:0] kernel_base,
  output logic             done,
  output logic [31:0]      alloc_addr,
  output logic [2:0]       status
);

  localparam logic BK_RUN  = 1'b0;
  localparam logic BK_WAIT = 1'b1;

  logic              state;
  logic [LINK_W-1:0] top;
  logic              top_null;
  logic              link_we;
  logic              link_re;
  logic [LINK_W-1:0] link_rdata;
  logic [31:0]       top_addr;

  assign top_null = top[FW];
  assign pop      = (state == BK_RUN) && !empty;
  assign link_we  = pop && (head.op == OP_PUSH);
  assign link_re  = pop && (head.op == OP_ALLOC) && !top_null;
  assign top_addr = ({{(32 - FW){1'b0}}, top[FW-1:0]} << PAGE_SHIFT) + kernel_base;

  // Link memory: next_link[frame] holds the top that the frame was pushed over.
  fpsa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (FRAME_COUNT)
  ) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (head.frame),
    .wdata (top),
    .re    (link_re),
    .raddr (top[FW-1:0]),
    .rdata (link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_RUN;
      top   <= {1'b1, {FW{1'b0}}};
      done  <= 1'b0;
    end else begin
      done <= pop;
      case (state)
        BK_RUN: begin
          if (link_we) begin
            top <= {1'b0, head.frame};
          end
          if (link_re) begin
            state <= BK_WAIT;
          end
        end
        BK_WAIT: begin
          top   <= link_rdata;
          state <= BK_RUN;
        end
        default: state <= BK_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      alloc_addr <= '0;
      case (head.op)
        OP_ALLOC: begin
          if (top_null) begin
            status <= ST_EMPTY;
          end else begin
            status     <= ST_OK;
            alloc_addr <= top_addr;
          end
        end
        OP_PUSH:   status <= ST_OK;
        default:   status <= head.status;
      endcase
    end
  end

  a_no_pop_in_wait: assert property (@(posedge clk) disable iff (rst)
    state == BK_WAIT |-> !pop)
    else $error("item taken while top reload pending");

  a_read_leads_wait: assert property (@(posedge clk) disable iff (rst)
    link_re |=> state == BK_WAIT && done)
    else $error("link read not followed by reload");

  a_zero_addr_on_error: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> alloc_addr == '0)
    else $error("nonzero address with error status");

endmodule
`default_nettype wire

>>> hdl/free_page_stack_allocator_unit.sv
// Order: an accepted command is written into the command queue; the back end pops it,
//   registering done, alloc_addr and status together; each item queued ahead comes first.
// The back end retires a free, a rejected request or an allocate on an empty stack with
//   no wait; an allocate that pops a frame waits in BK_WAIT for the link memory read.
// busy is high while the two-entry command queue is full; done cannot be held off.
// Reset (rst, synchronous, active high): stack and queue empty, config at defaults, done low.
`default_nettype none
module free_page_stack_allocator_unit import fpsa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [31:0] page_addr,
  output logic             done,
  output logic [31:0]      alloc_addr,
  output logic [2:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t   cfg;
  entry_t front_entry;
  entry_t head;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  logic   accept;

  // Config writes are always taken; an index past the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kernel_base <= 32'h8000_0000;
      cfg.kernel_end  <= 32'h8010_0000;
      cfg.phys_top    <= 29'h0E00_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KERNEL_BASE: cfg.kernel_base <= cfg_data;
        CFG_KERNEL_END:  cfg.kernel_end  <= cfg_data;
        CFG_PHYS_TOP:    cfg.phys_top    <= cfg_data[28:0];
        default:         cfg.phys_top    <= cfg.phys_top;
      endcase
    end
  end

  // Hold off new commands only while the queue has no room.
  assign busy   = q_full;
  assign accept = start && !busy;

  // Front end: classify the command and run the address checks at accept time.
  fpsa_front u_front (
    .command   (command),
    .page_addr (page_addr),
    .cfg       (cfg),
    .entry     (front_entry)
  );

  // Decouple classification from stack work.
  fpsa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (head)
  );

  // Back end: pop/push the stack and register the result.
  fpsa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (q_empty),
    .head        (head),
    .pop         (q_pop),
    .kernel_base (cfg.kernel_base),
    .done        (done),
    .alloc_addr  (alloc_addr),
    .status      (status)
  );

endmodule
`default_nettype wire
